[src/assert_macros.svh]
// Assertion macros for the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CHK_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("%m: check failed");

// Temporal property checked at every clock edge out of reset.
`define CHK_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");

`endif

[src/ltxbp_pkg.sv]
// Package for the legacy transaction boundary parser: beat types, phase codes
// and field length constants. No dependencies.
`timescale 1ns / 1ps

package ltxbp_pkg;

    localparam int COUNT_BITS = 32;
    localparam int ACC_BITS   = 64;

    localparam logic [7:0] CS_PREFIX_16 = 8'hfd;
    localparam logic [7:0] CS_PREFIX_32 = 8'hfe;

    localparam logic [3:0] CS_LEN_16 = 4'd2;
    localparam logic [3:0] CS_LEN_32 = 4'd4;
    localparam logic [3:0] CS_LEN_64 = 4'd8;

    localparam logic [5:0] VERSION_BYTES  = 6'd4;
    localparam logic [5:0] OUTPOINT_BYTES = 6'd36;
    localparam logic [5:0] SEQUENCE_BYTES = 6'd4;
    localparam logic [5:0] VALUE_BYTES    = 6'd8;
    localparam logic [5:0] LOCKTIME_BYTES = 6'd4;

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [3:0] {
        PH_VERSION,
        PH_IN_COUNT,
        PH_OUTPOINT,
        PH_IN_SLEN,
        PH_IN_SCRIPT,
        PH_SEQUENCE,
        PH_OUT_COUNT,
        PH_VALUE,
        PH_OUT_SLEN,
        PH_OUT_SCRIPT,
        PH_LOCKTIME
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_DONE,
        ST_BAD
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] tx_length;
        logic [31:0] input_count;
        logic [31:0] output_count;
        logic        malformed;
    } out_beat_t;

endpackage

[src/legacy_tx_boundary_parser_top.sv]
// Legacy transaction boundary parser, top level.
// Depends on ltxbp_pkg and assert_macros.svh.
//
// Usage:
//   s_valid/s_ready/s_data carry one buffer byte per beat, with last_byte
//   set on the final byte of the buffer. m_valid/m_ready/m_data carry one
//   result beat per completed transaction (length, input and output counts),
//   or a malformed beat when the buffer ends mid-transaction or a
//   CompactSize value exceeds the count width.
//   Throughput: one byte per cycle unless stalled; every byte only advances
//   the parse counters and the CompactSize accumulator in a single pass.
//   Latency: the result beat is valid in the cycle after the byte that
//   completes or breaks the transaction.
//   Stall: while a result waits and m_ready is low, s_ready is low; with
//   m_ready high a new byte is taken in the same cycle the result leaves.
//   Reset: aresetn low (synchronous) clears the parse state to expect the
//   version bytes of a new transaction and drops any pending result.
//   After a result the parse state restarts at a new transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module legacy_tx_boundary_parser_top
    import ltxbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    phase_t                phase_reg,    phase_next;
    logic [5:0]            field_reg,    field_next;
    logic [ACC_BITS-1:0]   acc_reg,      acc_next;
    logic [3:0]            vleft_reg,    vleft_next;
    logic [2:0]            vpos_reg,     vpos_next;
    logic [COUNT_BITS-1:0] items_reg,    items_next;
    logic [COUNT_BITS-1:0] script_reg,   script_next;
    logic [31:0]           bytes_reg,    bytes_next;
    logic [COUNT_BITS-1:0] ins_reg,      ins_next;
    logic [COUNT_BITS-1:0] outs_reg,     outs_next;
    logic                  m_valid_reg,  m_valid_next;
    out_beat_t             m_data_reg,   m_data_next;

    status_t               status;
    logic                  accept;
    logic [ACC_BITS-1:0]   acc_merged;
    logic [ACC_BITS-1:0]   vvalue;
    logic [COUNT_BITS-1:0] vcount;
    logic                  vdone;
    logic                  vover;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        acc_merged = acc_reg;
        acc_merged[{vpos_reg, 3'b000} +: 8] = s_data.data_byte;
        vvalue = (vleft_reg == 4'd0) ? ACC_BITS'(s_data.data_byte) : acc_merged;
        vcount = vvalue[COUNT_BITS-1:0];
        vdone  = (vleft_reg == 4'd0) ? (s_data.data_byte < CS_PREFIX_16)
                                     : (vleft_reg == 4'd1);
        vover  = (vvalue >> COUNT_BITS) != '0;
    end

    // next state
    always_comb begin
        phase_next  = phase_reg;
        field_next  = field_reg;
        acc_next    = acc_reg;
        vleft_next  = vleft_reg;
        vpos_next   = vpos_reg;
        items_next  = items_reg;
        script_next = script_reg;
        ins_next    = ins_reg;
        outs_next   = outs_reg;
        bytes_next  = (bytes_reg == 32'hFFFF_FFFF) ? bytes_reg : bytes_reg + 32'd1;
        status      = ST_NONE;

        case (phase_reg)
            PH_IN_COUNT, PH_IN_SLEN, PH_OUT_COUNT, PH_OUT_SLEN: begin
                if (vleft_reg == 4'd0 && !vdone) begin
                    vleft_next = (s_data.data_byte == CS_PREFIX_16) ? CS_LEN_16 :
                                 (s_data.data_byte == CS_PREFIX_32) ? CS_LEN_32 :
                                 CS_LEN_64;
                    acc_next   = '0;
                    vpos_next  = 3'd0;
                end else begin
                    if (vleft_reg != 4'd0) begin
                        acc_next   = acc_merged;
                        vpos_next  = vpos_reg + 3'd1;
                        vleft_next = vleft_reg - 4'd1;
                    end
                    if (vdone) begin
                        if (vover) begin
                            status = ST_BAD;
                        end else begin
                            case (phase_reg)
                                PH_IN_COUNT: begin
                                    ins_next   = vcount;
                                    items_next = vcount;
                                    if (vcount == '0) begin
                                        phase_next = PH_OUT_COUNT;
                                    end else begin
                                        phase_next = PH_OUTPOINT;
                                        field_next = OUTPOINT_BYTES;
                                    end
                                end
                                PH_IN_SLEN: begin
                                    script_next = vcount;
                                    if (vcount == '0) begin
                                        phase_next = PH_SEQUENCE;
                                        field_next = SEQUENCE_BYTES;
                                    end else begin
                                        phase_next = PH_IN_SCRIPT;
                                    end
                                end
                                PH_OUT_COUNT: begin
                                    outs_next  = vcount;
                                    items_next = vcount;
                                    if (vcount == '0) begin
                                        phase_next = PH_LOCKTIME;
                                        field_next = LOCKTIME_BYTES;
                                    end else begin
                                        phase_next = PH_VALUE;
                                        field_next = VALUE_BYTES;
                                    end
                                end
                                default: begin
                                    script_next = vcount;
                                    if (vcount != '0) begin
                                        phase_next = PH_OUT_SCRIPT;
                                    end else begin
                                        items_next = items_reg - COUNT_ONE;
                                        if (items_reg == COUNT_ONE) begin
                                            phase_next = PH_LOCKTIME;
                                            field_next = LOCKTIME_BYTES;
                                        end else begin
                                            phase_next = PH_VALUE;
                                            field_next = VALUE_BYTES;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            PH_IN_SCRIPT: begin
                script_next = script_reg - COUNT_ONE;
                if (script_reg == COUNT_ONE) begin
                    phase_next = PH_SEQUENCE;
                    field_next = SEQUENCE_BYTES;
                end
            end
            PH_OUT_SCRIPT: begin
                script_next = script_reg - COUNT_ONE;
                if (script_reg == COUNT_ONE) begin
                    items_next = items_reg - COUNT_ONE;
                    if (items_reg == COUNT_ONE) begin
                        phase_next = PH_LOCKTIME;
                        field_next = LOCKTIME_BYTES;
                    end else begin
                        phase_next = PH_VALUE;
                        field_next = VALUE_BYTES;
                    end
                end
            end
            PH_VERSION, PH_OUTPOINT, PH_SEQUENCE, PH_VALUE, PH_LOCKTIME: begin
                field_next = field_reg - 6'd1;
                if (field_reg == 6'd1) begin
                    case (phase_reg)
                        PH_VERSION:  phase_next = PH_IN_COUNT;
                        PH_OUTPOINT: phase_next = PH_IN_SLEN;
                        PH_SEQUENCE: begin
                            items_next = items_reg - COUNT_ONE;
                            if (items_reg == COUNT_ONE) begin
                                phase_next = PH_OUT_COUNT;
                            end else begin
                                phase_next = PH_OUTPOINT;
                                field_next = OUTPOINT_BYTES;
                            end
                        end
                        PH_VALUE:    phase_next = PH_OUT_SLEN;
                        default:     status = ST_DONE;
                    endcase
                end
            end
            default: begin
                status = ST_BAD;
            end
        endcase

        if (status == ST_NONE && s_data.last_byte) begin
            status = ST_BAD;
        end

        // restart at a new transaction after any result
        if (status != ST_NONE) begin
            phase_next  = PH_VERSION;
            field_next  = VERSION_BYTES;
            acc_next    = '0;
            vleft_next  = 4'd0;
            vpos_next   = 3'd0;
            items_next  = '0;
            script_next = '0;
            bytes_next  = 32'd0;
            ins_next    = '0;
            outs_next   = '0;
        end
    end

    // result beat
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (accept && status != ST_NONE) begin
            m_valid_next = 1'b1;
            if (status == ST_DONE) begin
                m_data_next.tx_length    = bytes_next == 32'd0 ? bytes_reg + 32'd1
                                                               : bytes_reg + 32'd1;
                m_data_next.input_count  = 32'(ins_reg);
                m_data_next.output_count = 32'(outs_reg);
                m_data_next.malformed    = 1'b0;
            end else begin
                m_data_next.tx_length    = 32'd0;
                m_data_next.input_count  = 32'd0;
                m_data_next.output_count = 32'd0;
                m_data_next.malformed    = 1'b1;
            end
            if (bytes_reg == 32'hFFFF_FFFF && status == ST_DONE) begin
                m_data_next.tx_length = bytes_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_VERSION;
            field_reg   <= VERSION_BYTES;
            acc_reg     <= '0;
            vleft_reg   <= 4'd0;
            vpos_reg    <= 3'd0;
            items_reg   <= '0;
            script_reg  <= '0;
            bytes_reg   <= 32'd0;
            ins_reg     <= '0;
            outs_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg  <= phase_next;
                field_reg  <= field_next;
                acc_reg    <= acc_next;
                vleft_reg  <= vleft_next;
                vpos_reg   <= vpos_next;
                items_reg  <= items_next;
                script_reg <= script_next;
                bytes_reg  <= bytes_next;
                ins_reg    <= ins_next;
                outs_reg   <= outs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `CHK_HOLDS(a_bad_zero, aclk, aresetn,
        !(m_valid_reg && m_data_reg.malformed) || (m_data_reg.tx_length == 32'd0 &&
        m_data_reg.input_count == 32'd0 && m_data_reg.output_count == 32'd0))
    `CHK_HOLDS(a_done_min_len, aclk, aresetn,
        !(m_valid_reg && !m_data_reg.malformed) || (m_data_reg.tx_length >= 32'd10))
    `CHK_PROP(a_last_restarts, aclk, aresetn,
        (accept && s_data.last_byte) |=> (phase_reg == PH_VERSION &&
        field_reg == VERSION_BYTES && bytes_reg == 32'd0 && m_valid_reg))
    `CHK_HOLDS(a_vleft_phase, aclk, aresetn,
        (vleft_reg == 4'd0) || phase_reg == PH_IN_COUNT || phase_reg == PH_IN_SLEN ||
        phase_reg == PH_OUT_COUNT || phase_reg == PH_OUT_SLEN)

endmodule

[bench/tb.sv]
// Self-checking bench for legacy_tx_boundary_parser_top: directed table, then random buffers.
// Carries its own transaction parser to predict each result beat.
// Depends on ltxbp_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb;
    import ltxbp_pkg::*;

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
        bit        drain;
    } byte_rec_t;

    localparam logic [63:0] CNT_MAX    = (64'd1 << COUNT_BITS) - 64'd1;
    localparam out_beat_t   NO_REPORT  = '0;
    localparam out_beat_t   BAD_REPORT = '{32'd0, 32'd0, 32'd0, 1'b1};
    localparam out_beat_t   MIN_REPORT = '{32'd10, 32'd0, 32'd0, 1'b0};

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    legacy_tx_boundary_parser_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    byte_rec_t byte_stream[$];
    out_beat_t tx_reports_due[$];
    int        n_fail     = 0;
    int        n_accepted = 0;
    int        n_total    = 0;

    // Parser state of the predictor
    phase_t                ph;
    logic [5:0]            fixed_left;
    logic [63:0]           acc;
    logic [3:0]            vb_left;
    logic [2:0]            vpos;
    logic [COUNT_BITS-1:0] items_rem;
    logic [COUNT_BITS-1:0] script_rem;
    logic [COUNT_BITS-1:0] n_in;
    logic [COUNT_BITS-1:0] n_out;
    logic [31:0]           byte_cnt;

    task automatic clear_parser();
        ph         = PH_VERSION;
        fixed_left = VERSION_BYTES;
        acc        = '0;
        vb_left    = '0;
        vpos       = '0;
        items_rem  = '0;
        script_rem = '0;
        n_in       = '0;
        n_out      = '0;
        byte_cnt   = '0;
    endtask

    task automatic finish_output();
        items_rem = items_rem - COUNT_ONE;
        if (items_rem == '0) begin
            ph         = PH_LOCKTIME;
            fixed_left = LOCKTIME_BYTES;
        end else begin
            ph         = PH_VALUE;
            fixed_left = VALUE_BYTES;
        end
    endtask

    task automatic close_varint(input logic [63:0] v, output status_t st);
        st = ST_NONE;
        if (v > CNT_MAX) begin
            st = ST_BAD;
        end else begin
            case (ph)
                PH_IN_COUNT: begin
                    n_in      = v[COUNT_BITS-1:0];
                    items_rem = v[COUNT_BITS-1:0];
                    if (v == '0) begin
                        ph = PH_OUT_COUNT;
                    end else begin
                        ph         = PH_OUTPOINT;
                        fixed_left = OUTPOINT_BYTES;
                    end
                end
                PH_IN_SLEN: begin
                    script_rem = v[COUNT_BITS-1:0];
                    if (v == '0) begin
                        ph         = PH_SEQUENCE;
                        fixed_left = SEQUENCE_BYTES;
                    end else begin
                        ph = PH_IN_SCRIPT;
                    end
                end
                PH_OUT_COUNT: begin
                    n_out     = v[COUNT_BITS-1:0];
                    items_rem = v[COUNT_BITS-1:0];
                    if (v == '0) begin
                        ph         = PH_LOCKTIME;
                        fixed_left = LOCKTIME_BYTES;
                    end else begin
                        ph         = PH_VALUE;
                        fixed_left = VALUE_BYTES;
                    end
                end
                default: begin
                    script_rem = v[COUNT_BITS-1:0];
                    if (v == '0) finish_output();
                    else ph = PH_OUT_SCRIPT;
                end
            endcase
        end
    endtask

    task automatic parse_tx_byte(input in_beat_t bt, output bit got, output out_beat_t rep);
        status_t    st;
        logic [7:0] b;
        st  = ST_NONE;
        b   = bt.data_byte;
        rep = NO_REPORT;
        if (byte_cnt != 32'hffff_ffff) byte_cnt = byte_cnt + 32'd1;
        case (ph)
            PH_IN_COUNT, PH_IN_SLEN, PH_OUT_COUNT, PH_OUT_SLEN: begin
                if (vb_left == '0) begin
                    if (b < CS_PREFIX_16) begin
                        close_varint({56'd0, b}, st);
                    end else begin
                        vb_left = (b == CS_PREFIX_16) ? CS_LEN_16 :
                                  (b == CS_PREFIX_32) ? CS_LEN_32 : CS_LEN_64;
                        acc     = '0;
                        vpos    = '0;
                    end
                end else begin
                    acc     = acc | (64'(b) << {vpos, 3'b000});
                    vpos    = vpos + 3'd1;
                    vb_left = vb_left - 4'd1;
                    if (vb_left == '0) close_varint(acc, st);
                end
            end
            PH_IN_SCRIPT: begin
                script_rem = script_rem - COUNT_ONE;
                if (script_rem == '0) begin
                    ph         = PH_SEQUENCE;
                    fixed_left = SEQUENCE_BYTES;
                end
            end
            PH_OUT_SCRIPT: begin
                script_rem = script_rem - COUNT_ONE;
                if (script_rem == '0) finish_output();
            end
            PH_VERSION, PH_OUTPOINT, PH_SEQUENCE, PH_VALUE, PH_LOCKTIME: begin
                fixed_left = fixed_left - 6'd1;
                if (fixed_left == '0) begin
                    case (ph)
                        PH_VERSION:  ph = PH_IN_COUNT;
                        PH_OUTPOINT: ph = PH_IN_SLEN;
                        PH_SEQUENCE: begin
                            items_rem = items_rem - COUNT_ONE;
                            if (items_rem == '0) begin
                                ph = PH_OUT_COUNT;
                            end else begin
                                ph         = PH_OUTPOINT;
                                fixed_left = OUTPOINT_BYTES;
                            end
                        end
                        PH_VALUE:    ph = PH_OUT_SLEN;
                        default:     st = ST_DONE;
                    endcase
                end
            end
            default: st = ST_BAD;
        endcase
        if (st == ST_NONE && bt.last_byte) st = ST_BAD;
        got = (st != ST_NONE);
        if (st == ST_DONE) rep = '{byte_cnt, n_in[31:0], n_out[31:0], 1'b0};
        else if (st == ST_BAD) rep = BAD_REPORT;
        if (got) clear_parser();
    endtask

    // Random buffer generation
    logic [7:0] tx_bytes[$];
    int         varint_no;
    bit         poisoned;

    function automatic logic [63:0] pick_len();
        if ($urandom_range(0, 4) != 0) return 64'($urandom_range(0, 12));
        return 64'($urandom_range(253, 300));
    endfunction

    task automatic put_varint(input logic [63:0] v, input int poison);
        int          enc;
        int          nb;
        logic [63:0] bad;
        if (varint_no == poison) begin
            bad = {32'($urandom_range(1, 32'hffff_ffff)), 32'($urandom)};
            tx_bytes.push_back(8'hff);
            for (int k = 0; k < 8; k++) tx_bytes.push_back(bad[8*k +: 8]);
            poisoned = 1'b1;
        end else begin
            enc = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            if (v >= 64'd253 && enc == 0) enc = 1;
            case (enc)
                0: begin tx_bytes.push_back(v[7:0]); nb = 0; end
                1: begin tx_bytes.push_back(CS_PREFIX_16); nb = 2; end
                2: begin tx_bytes.push_back(CS_PREFIX_32); nb = 4; end
                default: begin tx_bytes.push_back(8'hff); nb = 8; end
            endcase
            for (int k = 0; k < nb; k++) tx_bytes.push_back(v[8*k +: 8]);
        end
        varint_no++;
    endtask

    task automatic gen_tx(input int poison);
        int          nin;
        int          nout;
        logic [63:0] slen;
        tx_bytes.delete();
        varint_no = 0;
        poisoned  = 1'b0;
        repeat (4) tx_bytes.push_back(8'($urandom));
        nin = $urandom_range(0, 3);
        put_varint(64'(nin), poison);
        if (poisoned) return;
        for (int i = 0; i < nin; i++) begin
            repeat (36) tx_bytes.push_back(8'($urandom));
            slen = pick_len();
            put_varint(slen, poison);
            if (poisoned) return;
            repeat (int'(slen)) tx_bytes.push_back(8'($urandom));
            repeat (4) tx_bytes.push_back(8'($urandom));
        end
        nout = $urandom_range(0, 3);
        put_varint(64'(nout), poison);
        if (poisoned) return;
        for (int i = 0; i < nout; i++) begin
            repeat (8) tx_bytes.push_back(8'($urandom));
            slen = pick_len();
            put_varint(slen, poison);
            if (poisoned) return;
            repeat (int'(slen)) tx_bytes.push_back(8'($urandom));
        end
        repeat (4) tx_bytes.push_back(8'($urandom));
    endtask

    // Directed table: expected beat typed in only where it is obvious
    byte_rec_t dir_table [24] = '{
        '{'{8'h00, 1'b1}, 1'b1, BAD_REPORT, 1'b0},
        '{'{8'hff, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'hff, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'hff, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'hff, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'hff, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b1}, 1'b1, MIN_REPORT, 1'b0},
        '{'{8'h01, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'hff, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h01, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b0, NO_REPORT,  1'b0},
        '{'{8'h00, 1'b0}, 1'b1, BAD_REPORT, 1'b0}
    };

    task automatic build_stream();
        in_beat_t  chunk[$];
        byte_rec_t rec;
        int        kind;
        int        cut;
        int        n_reports;
        bit        drained;
        n_reports = 0;
        drained   = 1'b0;
        foreach (dir_table[i]) byte_stream.push_back(dir_table[i]);
        while (byte_stream.size() < 1124 || n_reports < 40) begin
            chunk.delete();
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(4, 30))
                    chunk.push_back(in_beat_t'{8'($urandom), $urandom_range(0, 11) == 0});
                chunk[chunk.size()-1].last_byte = 1'b1;
            end else begin
                gen_tx((kind == 8) ? $urandom_range(0, 3) : -1);
                foreach (tx_bytes[i]) chunk.push_back(in_beat_t'{tx_bytes[i], 1'b0});
                if (kind == 7) begin
                    cut = $urandom_range(0, chunk.size() - 2);
                    while (chunk.size() > cut + 1) void'(chunk.pop_back());
                    chunk[cut].last_byte = 1'b1;
                end else if (!poisoned) begin
                    chunk[chunk.size()-1].last_byte = 1'($urandom_range(0, 1));
                end
            end
            n_reports++;
            foreach (chunk[i]) begin
                rec.beat  = chunk[i];
                rec.typed = 1'b0;
                rec.want  = NO_REPORT;
                rec.drain = (i == 0) && !drained && byte_stream.size() >= 700;
                if (rec.drain) drained = 1'b1;
                byte_stream.push_back(rec);
            end
        end
    endtask

    // Sender: bursts and gaps, predict on every accepted beat
    byte_rec_t in_flight;
    int        gap_left   = 0;
    int        burst_left = 0;

    always @(posedge aclk) begin : sender
        bit        nv;
        bit        got;
        out_beat_t rep;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                parse_tx_byte(in_flight.beat, got, rep);
                if (in_flight.typed) tx_reports_due.push_back(in_flight.want);
                else if (got) tx_reports_due.push_back(rep);
                n_accepted++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_stream.size() > 0 &&
                             !(byte_stream[0].drain && tx_reports_due.size() != 0)) begin
                    in_flight = byte_stream.pop_front();
                    s_data   <= in_flight.beat;
                    nv        = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_valid <= nv;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Receiver: stall modes, one long hold-off
    int         mode       = 0;
    int         mode_left  = 0;
    int         hold_left  = 0;
    bit         hold_done  = 1'b0;
    logic [1:0] stall_ctr  = '0;

    always @(posedge aclk) begin : receiver
        bit        rdy;
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tx_reports_due.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %h", $time, m_data);
                    n_fail++;
                end else begin
                    want = tx_reports_due.pop_front();
                    check_field("tx_length", want.tx_length, m_data.tx_length);
                    check_field("input_count", want.input_count, m_data.input_count);
                    check_field("output_count", want.output_count, m_data.output_count);
                    check_field("malformed", 32'(want.malformed), 32'(m_data.malformed));
                end
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            stall_ctr = stall_ctr + 2'd1;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && n_accepted >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
                rdy       = 1'b0;
            end else begin
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (stall_ctr != 2'b11);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_ready <= rdy;
        end
    end

    initial begin
        clear_parser();
        build_stream();
        n_total = byte_stream.size();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (n_accepted < n_total) @(posedge aclk);
        while (tx_reports_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/ltxbp_pkg.sv
src/legacy_tx_boundary_parser_top.sv
bench/tb.sv
